// ===== rtl/bptc_pkg.sv =====
`default_nettype none
package bptc_pkg;

    // configuration register indexes
    localparam logic [7:0] CFG_T1    = 8'd0;
    localparam logic [7:0] CFG_T2    = 8'd1;
    localparam logic [7:0] CFG_T3    = 8'd2;
    localparam logic [7:0] CFG_P1    = 8'd3;
    localparam logic [7:0] CFG_P2_P3 = 8'd4;
    localparam logic [7:0] CFG_P4_P5 = 8'd5;
    localparam logic [7:0] CFG_P6_P7 = 8'd6;
    localparam logic [7:0] CFG_P8_P9 = 8'd7;

    localparam logic [63:0] FINE_OFFSET = 64'd128000;
    localparam logic [63:0] ADC_FULL    = 64'd1048576;
    localparam logic [63:0] DIV_SCALE   = 64'd3125;
    localparam logic [63:0] DEN_BIAS    = 64'h0000_8000_0000_0000;
    localparam logic [31:0] TEMP_ROUND  = 32'd128;

    typedef enum logic [4:0] {
        OP_NONE, OP_T1, OP_T3, OP_T5, OP_T7, OP_T8,
        OP_P1, OP_P2, OP_P3, OP_P4, OP_P5, OP_P6, OP_P7, OP_P8, OP_P9, OP_P10,
        OP_P12, OP_P13, OP_P14, OP_P15, OP_P16, OP_P17, OP_P18, OP_PZ
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE, ST_T1, ST_T3, ST_T5, ST_T7, ST_T8,
        ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8, ST_P9, ST_P10,
        ST_P11, ST_P12, ST_P13, ST_P14, ST_P15, ST_P16, ST_P17, ST_P18, ST_PZ,
        ST_MUL, ST_DIV, ST_DONE
    } t_state;

    typedef struct packed {
        t_op  op;
        logic mul_start;
        logic div_start;
        logic load_in;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic den_zero;
    } t_stat;

endpackage
`default_nettype wire

// ===== rtl/bptc_div.sv =====
`default_nettype none
module bptc_div
    import bptc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [63:0] i_den,
    output logic             o_done,
    output logic [63:0]      o_quot
);

    logic        r_busy, r_fix, r_done, r_neg;
    logic [5:0]  r_cnt;
    logic [63:0] r_q, r_r, r_dv;
    logic [63:0] trial;
    logic        ge;

    // remainder stays below the divisor magnitude, so the shifted value fits
    assign trial = {r_r[62:0], r_q[63]};
    assign ge    = (trial >= r_dv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[63] ^ i_den[63];
            r_q   <= i_num[63] ? (64'd0 - i_num) : i_num;
            r_dv  <= i_den[63] ? (64'd0 - i_den) : i_den;
            r_r   <= '0;
        end else if (r_busy) begin
            r_r <= ge ? (trial - r_dv) : trial;
            r_q <= {r_q[62:0], ge};
        end else if (r_fix) begin
            r_q <= r_neg ? (64'd0 - r_q) : r_q;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

`ifndef NO_ASSERTIONS
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider did not start");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (!r_busy && !r_fix))
        else $error("divider done while still iterating");
`endif

endmodule
`default_nettype wire

// ===== rtl/bptc_dp.sv =====
`default_nettype none
module bptc_dp
    import bptc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd_bus,
    output t_stat            o_stat,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_cmd,
    input  wire logic [19:0] i_raw_adc,
    output logic             o_kind,
    output logic [31:0]      o_temp_centi,
    output logic [31:0]      o_fine_temp,
    output logic [31:0]      o_pressure_q24_8,
    output logic             o_ok
);

    logic [15:0] r_cal_t1, r_cal_t2, r_cal_t3, r_cal_p1;
    logic [31:0] r_cal_p23, r_cal_p45, r_cal_p67, r_cal_p89;
    logic [31:0] r_fine;
    logic        r_kind;
    logic [19:0] r_adc;
    logic [63:0] r_a, r_b, r_m, r_x, r_y, r_p, r_h, r_d;
    logic [31:0] r_rtemp, r_rpres;
    logic        r_rok;
    logic        r_mbusy, r_mdone;
    logic [1:0]  r_mstep;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [31:0] d1, d2, m32, fine5;
    logic [63:0] xv, quot;
    logic        div_done;

    // one 32x32 multiplier, three passes give the low 64 bits of a 64x64 product
    always_comb begin
        case (r_mstep)
            2'd0:    begin mul_a = r_a[31:0];  mul_b = r_b[31:0];  end
            2'd1:    begin mul_a = r_a[31:0];  mul_b = r_b[63:32]; end
            default: begin mul_a = r_a[63:32]; mul_b = r_b[31:0];  end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
            r_mstep <= '0;
        end else begin
            r_mdone <= 1'b0;
            if (i_cmd_bus.mul_start) begin
                r_mbusy <= 1'b1;
                r_mstep <= '0;
            end else if (r_mbusy) begin
                r_mstep <= r_mstep + 2'd1;
                if (r_mstep == 2'd2) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_mbusy) begin
            if (r_mstep == 2'd0) r_m <= mul_p;
            else                 r_m[63:32] <= r_m[63:32] + mul_p[31:0];
        end
    end

    bptc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd_bus.div_start),
        .i_num   (r_m),
        .i_den   (r_d),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    assign d1    = {15'd0, r_adc[19:3]} - {15'd0, r_cal_t1, 1'b0};
    assign d2    = {16'd0, r_adc[19:4]} - {16'd0, r_cal_t1};
    assign m32   = r_m[31:0];
    assign fine5 = {r_fine[29:0], 2'b00} + r_fine + TEMP_ROUND;
    assign xv    = {{32{r_fine[31]}}, r_fine} - FINE_OFFSET;

    // configuration and fine temperature state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_t1  <= '0;
            r_cal_t2  <= '0;
            r_cal_t3  <= '0;
            r_cal_p1  <= '0;
            r_cal_p23 <= '0;
            r_cal_p45 <= '0;
            r_cal_p67 <= '0;
            r_cal_p89 <= '0;
            r_fine    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_T1:    r_cal_t1  <= i_cfg_data[15:0];
                    CFG_T2:    r_cal_t2  <= i_cfg_data[15:0];
                    CFG_T3:    r_cal_t3  <= i_cfg_data[15:0];
                    CFG_P1:    r_cal_p1  <= i_cfg_data[15:0];
                    CFG_P2_P3: r_cal_p23 <= i_cfg_data;
                    CFG_P4_P5: r_cal_p45 <= i_cfg_data;
                    CFG_P6_P7: r_cal_p67 <= i_cfg_data;
                    CFG_P8_P9: r_cal_p89 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd_bus.op == OP_T7)
                r_fine <= r_x[31:0] + 32'($signed(m32) >>> 14);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.load_in) begin
            r_kind <= i_cmd;
            r_adc  <= i_raw_adc;
        end
        case (i_cmd_bus.op)
            OP_T1: begin
                r_a <= {{32{d1[31]}}, d1};
                r_b <= {{48{r_cal_t2[15]}}, r_cal_t2};
            end
            OP_T3: begin
                r_x <= {{32{m32[31]}}, 32'($signed(m32) >>> 11)};
                r_a <= {{32{d2[31]}}, d2};
                r_b <= {{32{d2[31]}}, d2};
            end
            OP_T5: begin
                r_a <= {{32{m32[31]}}, 32'($signed(m32) >>> 12)};
                r_b <= {{48{r_cal_t3[15]}}, r_cal_t3};
            end
            OP_T8: r_rtemp <= 32'($signed(fine5) >>> 8);
            OP_P1: begin
                r_x <= xv;
                r_a <= xv;
                r_b <= xv;
            end
            OP_P2: begin
                r_h <= r_m;
                r_a <= r_m;
                r_b <= {{48{r_cal_p67[15]}}, r_cal_p67[15:0]};
            end
            OP_P3: begin
                r_y <= r_m;
                r_a <= r_x;
                r_b <= {{48{r_cal_p45[31]}}, r_cal_p45[31:16]};
            end
            OP_P4: begin
                r_y <= r_y + {r_m[46:0], 17'd0};
                r_a <= r_h;
                r_b <= {{48{r_cal_p23[31]}}, r_cal_p23[31:16]};
            end
            // word four is the low half, sign extended before the shift
            OP_P5: r_y <= r_y + {{13{r_cal_p45[15]}}, r_cal_p45[15:0], 35'd0};
            OP_P6: begin
                r_p <= 64'($signed(r_m) >>> 8);
                r_a <= r_x;
                r_b <= {{48{r_cal_p23[15]}}, r_cal_p23[15:0]};
            end
            OP_P7: r_x <= r_p + {r_m[51:0], 12'd0};
            OP_P8: begin
                r_a <= DEN_BIAS + r_x;
                r_b <= {48'd0, r_cal_p1};
            end
            OP_P9: begin
                r_d <= 64'($signed(r_m) >>> 33);
                r_p <= {(ADC_FULL[32:0] - {13'd0, r_adc}), 31'd0};
            end
            OP_P10: begin
                r_a <= r_p - r_y;
                r_b <= DIV_SCALE;
            end
            OP_P12: begin
                r_p <= quot;
                r_a <= 64'($signed(quot) >>> 13);
                r_b <= 64'($signed(quot) >>> 13);
            end
            OP_P13: begin
                r_a <= r_m;
                r_b <= {{48{r_cal_p89[31]}}, r_cal_p89[31:16]};
            end
            OP_P14: begin
                r_h <= 64'($signed(r_m) >>> 25);
                r_a <= r_p;
                r_b <= {{48{r_cal_p89[15]}}, r_cal_p89[15:0]};
            end
            OP_P15: r_y <= r_p + r_h;
            OP_P16: r_y <= r_y + 64'($signed(r_m) >>> 19);
            OP_P17: r_p <= 64'($signed(r_y) >>> 8)
                           + {{44{r_cal_p67[31]}}, r_cal_p67[31:16], 4'd0};
            OP_P18: begin
                r_rok <= 1'b1;
                if (r_p[63])            r_rpres <= '0;
                else if (|r_p[62:32])   r_rpres <= '1;
                else                    r_rpres <= r_p[31:0];
            end
            OP_PZ: begin
                r_rok   <= 1'b0;
                r_rpres <= '0;
            end
            default: ;
        endcase
    end

    // output register, parts the result side from the working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.out_load) begin
            o_kind           <= r_kind;
            o_temp_centi     <= r_kind ? 32'd0 : r_rtemp;
            o_fine_temp      <= r_fine;
            o_pressure_q24_8 <= r_kind ? r_rpres : 32'd0;
            o_ok             <= r_kind ? r_rok : 1'b1;
        end
    end

    assign o_stat.mul_done = r_mdone;
    assign o_stat.div_done = div_done;
    assign o_stat.den_zero = (r_d == 64'd0);

endmodule
`default_nettype wire

// ===== rtl/bptc_ctrl.sv =====
`default_nettype none
module bptc_ctrl
    import bptc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    input  wire logic  i_cmd,
    output logic       o_valid,
    input  wire logic  i_stall,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd_bus
);

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   r_ovalid, n_ovalid;
    logic   accept;

    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ret    <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state             = r_state;
        n_ret               = r_ret;
        o_cmd_bus.op        = OP_NONE;
        o_cmd_bus.mul_start = 1'b0;
        o_cmd_bus.div_start = 1'b0;
        o_cmd_bus.load_in   = 1'b0;
        o_cmd_bus.out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd_bus.load_in = 1'b1;
                    n_state = i_cmd ? ST_P1 : ST_T1;
                end
            end
            ST_T1: begin
                o_cmd_bus.op = OP_T1; o_cmd_bus.mul_start = 1'b1;
                n_state = ST_MUL; n_ret = ST_T3;
            end
            ST_T3: begin
                o_cmd_bus.op = OP_T3; o_cmd_bus.mul_start = 1'b1;
                n_state = ST_MUL; n_ret = ST_T5;
            end
            ST_T5: begin
                o_cmd_bus.op = OP_T5; o_cmd_bus.mul_start = 1'b1;
                n_state = ST_MUL; n_ret = ST_T7;
            end
            ST_T7: begin o_cmd_bus.op = OP_T7; n_state = ST_T8; end
            ST_T8: begin o_cmd_bus.op = OP_T8; n_state = ST_DONE; end
            ST_P1: begin
                o_cmd_bus.op = OP_P1; o_cmd_bus.mul_start = 1'b1;
                n_state = ST_MUL; n_ret = ST_P2;
            end
            ST_P2: begin
                o_cmd_bus.op = OP_P2; o_cmd_bus.mul_start = 1'b1;
                n_state = ST_MUL; n_ret = ST_P3;
            end
            ST_P3: begin
                o_cmd_bus.op = OP_P3; o_cmd_bus.mul_start = 1'b1;
                n_state = ST_MUL; n_ret = ST_P4;
            end
            ST_P4: begin o_cmd_bus.op = OP_P4; n_state = ST_P5; end
            ST_P5: begin
                o_cmd_bus.op = OP_P5; o_cmd_bus.mul_start = 1'b1;
                n_state = ST_MUL; n_ret = ST_P6;
            end
            ST_P6: begin
                o_cmd_bus.op = OP_P6; o_cmd_bus.mul_start = 1'b1;
                n_state = ST_MUL; n_ret = ST_P7;
            end
            ST_P7: begin o_cmd_bus.op = OP_P7; n_state = ST_P8; end
            ST_P8: begin
                o_cmd_bus.op = OP_P8; o_cmd_bus.mul_start = 1'b1;
                n_state = ST_MUL; n_ret = ST_P9;
            end
            ST_P9: begin o_cmd_bus.op = OP_P9; n_state = ST_P10; end
            ST_P10: begin
                if (i_stat.den_zero) begin
                    n_state = ST_PZ;
                end else begin
                    o_cmd_bus.op = OP_P10; o_cmd_bus.mul_start = 1'b1;
                    n_state = ST_MUL; n_ret = ST_P11;
                end
            end
            ST_P11: begin
                o_cmd_bus.div_start = 1'b1;
                n_state = ST_DIV; n_ret = ST_P12;
            end
            ST_P12: begin
                o_cmd_bus.op = OP_P12; o_cmd_bus.mul_start = 1'b1;
                n_state = ST_MUL; n_ret = ST_P13;
            end
            ST_P13: begin
                o_cmd_bus.op = OP_P13; o_cmd_bus.mul_start = 1'b1;
                n_state = ST_MUL; n_ret = ST_P14;
            end
            ST_P14: begin
                o_cmd_bus.op = OP_P14; o_cmd_bus.mul_start = 1'b1;
                n_state = ST_MUL; n_ret = ST_P15;
            end
            ST_P15: begin o_cmd_bus.op = OP_P15; n_state = ST_P16; end
            ST_P16: begin o_cmd_bus.op = OP_P16; n_state = ST_P17; end
            ST_P17: begin o_cmd_bus.op = OP_P17; n_state = ST_P18; end
            ST_P18: begin o_cmd_bus.op = OP_P18; n_state = ST_DONE; end
            ST_PZ:  begin o_cmd_bus.op = OP_PZ;  n_state = ST_DONE; end
            ST_MUL: begin
                if (i_stat.mul_done) n_state = r_ret;
            end
            ST_DIV: begin
                if (i_stat.div_done) n_state = r_ret;
            end
            ST_DONE: begin
                // wait for the output register to free up
                if (!r_ovalid || !i_stall) begin
                    o_cmd_bus.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (o_cmd_bus.out_load)        n_ovalid = 1'b1;
        else if (r_ovalid && !i_stall) n_ovalid = 1'b0;
        else                           n_ovalid = r_ovalid;
    end

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != ST_IDLE))
        else $error("transaction accepted but controller stayed idle");
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_bus.out_load |=> r_ovalid)
        else $error("result loaded but not presented");
`endif

endmodule
`default_nettype wire

// ===== rtl/baro_temp_pressure_compensation.sv =====
// channel   direction  handshake              payload
// input     in         i_valid / o_stall      i_cmd, i_raw_adc
// result    out        o_valid / i_stall      o_kind, o_temp_centi, o_fine_temp,
//                                             o_pressure_q24_8, o_ok
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// result is presented once every step of the transaction is done, with a zero divisor
// skipping the division, and the next transaction is taken in that same cycle; the
// steps are paced by the shared 32x32 multiplier, which builds each 64-bit product
// in passes, and by the one-bit-per-cycle 64-bit divider.
// one transaction in flight; a finished result waits in the output register
// while the next transaction is taken, and a result stalled there holds back the
// one behind it. reset is synchronous, active low, and clears calibration and the
// stored fine temperature.
`default_nettype none
module baro_temp_pressure_compensation
    import bptc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_cmd,
    input  wire logic [19:0] i_raw_adc,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_kind,
    output logic [31:0]      o_temp_centi,
    output logic [31:0]      o_fine_temp,
    output logic [31:0]      o_pressure_q24_8,
    output logic             o_ok,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    t_cmd  cmd_bus;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    bptc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_cmd     (i_cmd),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .i_stat    (stat),
        .o_cmd_bus (cmd_bus)
    );

    bptc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_bus        (cmd_bus),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (i_cmd),
        .i_raw_adc        (i_raw_adc),
        .o_kind           (o_kind),
        .o_temp_centi     (o_temp_centi),
        .o_fine_temp      (o_fine_temp),
        .o_pressure_q24_8 (o_pressure_q24_8),
        .o_ok             (o_ok)
    );

endmodule
`default_nettype wire
